>>> hw/rtl/otr_pkg.sv
package otr_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_SELECT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_POP    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_OPEN      = 2'd1,
    ST_COMPLETED = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] handle;
    logic [31:0] issue_time;
    logic [13:0] source_id;
    logic [7:0]  thread_id;
    logic [31:0] cur_time;
    logic [2:0]  entry_index;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  found_index;
    logic [15:0] handle_out;
    logic [31:0] time_out;
    logic        waiting;
  } res_t;

  // Command fields broadcast to every cell.
  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] handle;
    logic [31:0] issue_time;
    logic [13:0] source_id;
    logic [7:0]  thread_id;
  } cell_req_t;

  // Where a cell sits relative to the response and command pointers.
  typedef struct packed {
    logic in_window;
    logic upper;
  } cell_pos_t;

  // Lookup priority carried from cell to cell.
  typedef struct packed {
    logic hi;
    logic lo;
  } chain_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] handle;
    logic [31:0] issue_time;
  } cell_view_t;

endpackage

>>> hw/rtl/outstanding_transaction_ring.sv
// Outstanding transaction ring: a row of ENTRIES cells, each holding one transaction
// (empty, open or completed), walked by a head, a command and a response pointer.
// An item is taken when start is high and busy is low; the next cycle, with busy
// high, all cells compare in parallel, the response lookup priority ripples along
// the cell chain from the response pointer, and the touched cell is updated. In the
// cycle after that the result is on res_o, marked by done_o for exactly one cycle,
// and a new item may be started in that same cycle. No new item is taken while busy
// is high, so each item is finished before the next is taken. The receiver cannot
// stall: a result that is not taken in its cycle is gone.
module outstanding_transaction_ring #(
  parameter int ENTRIES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  otr_pkg::cmd_t cmd_i,
  output logic          done_o,
  output otr_pkg::res_t res_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int XW = (IW > 3) ? IW : 3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e            state_q;
  otr_pkg::cmd_t     cmd_q;
  logic [IW-1:0]     head_q, cmd_ptr_q, rsp_ptr_q;
  logic [IW-1:0]     head_d, cmd_ptr_d, rsp_ptr_d;
  logic              done_q;
  otr_pkg::res_t     res_q, res_d;

  otr_pkg::cell_req_t  req;
  otr_pkg::cell_pos_t  pos  [ENTRIES];
  otr_pkg::chain_t     chain[ENTRIES+1];
  otr_pkg::cell_view_t view [ENTRIES];
  logic [ENTRIES-1:0]  win, tgt, wr;
  logic                any_hi;

  otr_pkg::cell_view_t sel_view;
  logic [IW-1:0]       sel_idx;
  logic [XW-1:0]       sel_idx_x;
  logic                ok;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
    return (p == IW'(ENTRIES - 1)) ? '0 : p + 1'b1;
  endfunction

  assign busy = (state_q == S_EXEC);

  assign req.opcode     = cmd_q.opcode;
  assign req.handle     = cmd_q.handle;
  assign req.issue_time = cmd_q.issue_time;
  assign req.source_id  = cmd_q.source_id;
  assign req.thread_id  = cmd_q.thread_id;

  assign chain[0] = '0;
  assign any_hi   = chain[ENTRIES].hi;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    // The search window runs from the response pointer up to the command pointer,
    // and covers the whole ring when the two are equal.
    always_comb begin
      pos[i].upper = (IW'(i) >= rsp_ptr_q);
      if (rsp_ptr_q == cmd_ptr_q) begin
        pos[i].in_window = 1'b1;
      end else if (rsp_ptr_q < cmd_ptr_q) begin
        pos[i].in_window = (IW'(i) >= rsp_ptr_q) && (IW'(i) < cmd_ptr_q);
      end else begin
        pos[i].in_window = (IW'(i) >= rsp_ptr_q) || (IW'(i) < cmd_ptr_q);
      end
    end

    always_comb begin
      case (cmd_q.opcode)
        otr_pkg::OP_PUSH:   tgt[i] = (IW'(i) == head_q);
        otr_pkg::OP_SELECT: tgt[i] = (IW'(i) == cmd_ptr_q);
        otr_pkg::OP_LOOKUP: tgt[i] = win[i];
        otr_pkg::OP_POP:    tgt[i] = (int'(cmd_q.entry_index) == i);
        default:            tgt[i] = 1'b0;
      endcase
    end

    assign wr[i] = (state_q == S_EXEC) && ok && tgt[i];

    otr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .req_i    (req),
      .pos_i    (pos[i]),
      .any_hi_i (any_hi),
      .write_i  (wr[i]),
      .chain_i  (chain[i]),
      .chain_o  (chain[i+1]),
      .win_o    (win[i]),
      .view_o   (view[i])
    );
  end

  always_comb begin
    sel_view = '0;
    sel_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tgt[i]) begin
        sel_view = sel_view | view[i];
        sel_idx  = sel_idx | IW'(i);
      end
    end
  end

  assign sel_idx_x = XW'(sel_idx);

  always_comb begin
    case (cmd_q.opcode)
      otr_pkg::OP_PUSH:   ok = (|tgt) && (sel_view.status == otr_pkg::ST_EMPTY);
      otr_pkg::OP_SELECT: ok = (sel_view.status == otr_pkg::ST_OPEN) &&
                               (sel_view.issue_time <= cmd_q.cur_time);
      otr_pkg::OP_LOOKUP: ok = |win;
      otr_pkg::OP_POP:    ok = (|tgt) && (sel_view.status == otr_pkg::ST_COMPLETED);
      default:            ok = 1'b0;
    endcase
  end

  always_comb begin
    head_d    = head_q;
    cmd_ptr_d = cmd_ptr_q;
    rsp_ptr_d = rsp_ptr_q;
    if (ok && (cmd_q.opcode == otr_pkg::OP_PUSH)) begin
      head_d = ring_next(head_q);
    end
    if (ok && (cmd_q.opcode == otr_pkg::OP_SELECT)) begin
      cmd_ptr_d = ring_next(cmd_ptr_q);
    end
    // Only an in-order response moves the response pointer.
    if (ok && (cmd_q.opcode == otr_pkg::OP_LOOKUP) && (sel_idx == rsp_ptr_q)) begin
      rsp_ptr_d = ring_next(rsp_ptr_q);
    end

    res_d             = '0;
    res_d.ok          = ok;
    res_d.waiting     = (rsp_ptr_d != cmd_ptr_d);
    if (ok) begin
      res_d.found_index = sel_idx_x[2:0];
      if (cmd_q.opcode == otr_pkg::OP_PUSH) begin
        res_d.handle_out = cmd_q.handle;
        res_d.time_out   = cmd_q.issue_time;
      end else begin
        res_d.handle_out = sel_view.handle;
        res_d.time_out   = sel_view.issue_time;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmd_q     <= '0;
      head_q    <= '0;
      cmd_ptr_q <= '0;
      rsp_ptr_q <= '0;
      done_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      done_q <= (state_q == S_EXEC);
      case (state_q)
        S_IDLE: begin
          if (start) begin
            cmd_q   <= cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          head_q    <= head_d;
          cmd_ptr_q <= cmd_ptr_d;
          rsp_ptr_q <= rsp_ptr_d;
          res_q     <= res_d;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_exec_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o)
    else $error("execute cycle produced no result");

  a_start_enters_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not enter execution");

  a_single_winner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(win))
    else $error("lookup selected more than one entry");

  a_fail_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.ok) |-> (res_o.found_index == 3'd0 && res_o.handle_out == 16'd0 &&
                               res_o.time_out == 32'd0))
    else $error("failed operation reported entry data");
`endif

endmodule

>>> hw/rtl/otr_cell.sv
module otr_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  otr_pkg::cell_req_t req_i,
  input  otr_pkg::cell_pos_t pos_i,
  input  logic               any_hi_i,
  input  logic               write_i,
  input  otr_pkg::chain_t    chain_i,
  output otr_pkg::chain_t    chain_o,
  output logic               win_o,
  output otr_pkg::cell_view_t view_o
);

  otr_pkg::status_e status_q;
  logic [15:0]      handle_q;
  logic [31:0]      time_q;
  logic [13:0]      source_q;
  logic [7:0]       thread_q;
  logic             hit;

  assign hit = (status_q == otr_pkg::ST_COMPLETED) && (source_q == req_i.source_id) &&
               (thread_q == req_i.thread_id) && pos_i.in_window;

  // Cells at or above the response pointer are searched first, lowest index first;
  // the cells below it only win when no upper cell matched.
  assign chain_o.hi = chain_i.hi | (hit & pos_i.upper);
  assign chain_o.lo = chain_i.lo | (hit & ~pos_i.upper);
  assign win_o      = hit & (pos_i.upper ? ~chain_i.hi : (~any_hi_i & ~chain_i.lo));

  assign view_o.status     = status_q;
  assign view_o.handle     = handle_q;
  assign view_o.issue_time = time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= otr_pkg::ST_EMPTY;
    end else if (write_i) begin
      case (req_i.opcode)
        otr_pkg::OP_PUSH:   status_q <= otr_pkg::ST_OPEN;
        otr_pkg::OP_SELECT: status_q <= otr_pkg::ST_COMPLETED;
        otr_pkg::OP_POP:    status_q <= otr_pkg::ST_EMPTY;
        default:            status_q <= status_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_i && (req_i.opcode == otr_pkg::OP_PUSH)) begin
      handle_q <= req_i.handle;
      time_q   <= req_i.issue_time;
      source_q <= req_i.source_id;
      thread_q <= req_i.thread_id;
    end
  end

endmodule
